>>> sv/sensor_frame_checker_core_macros.svh
// Assertion macros for the checker RTL.
`ifndef SENSOR_FRAME_CHECKER_CORE_MACROS_SVH
`define SENSOR_FRAME_CHECKER_CORE_MACROS_SVH

// Clocked check, quiet while reset is held.
`define SFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked check that also holds during reset.
`define SFC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> sv/sfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sfc_pkg;

    localparam logic [7:0] HEADER_MARK   = 8'haa;
    localparam logic [7:0] TAIL_MARK     = 8'hbb;
    localparam logic [7:0] TYPE_MARK     = 8'h00;
    localparam int         PAYLOAD_FIRST = 3;
    localparam int         PAYLOAD_DEPTH = 10;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FRAMING   = 3'd1;
    localparam logic [2:0] ST_TYPE      = 3'd2;
    localparam logic [2:0] ST_LENGTH    = 3'd3;
    localparam logic [2:0] ST_CHECKSUM  = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] humidity_raw;
        logic [15:0] temperature_raw;
        logic [15:0] light_raw;
        logic [15:0] gas_raw;
        logic [15:0] soil_raw;
    } t_out_beat;

    typedef struct packed {
        logic     go;
        t_in_beat beat;
    } t_step_req;

endpackage
`default_nettype wire

>>> sv/sfc_frame_state.sv
`timescale 1ns / 1ps
`default_nettype none
module sfc_frame_state
    import sfc_pkg::*;
#(
    parameter int MAX_CHUNK = 50
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_step_req i_step,
    output t_out_beat      o_result
);

    localparam int POS_W = $clog2(MAX_CHUNK + 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_first, n_first;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_prev, n_prev;
    logic [7:0]       r_older, n_older;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_pay [PAYLOAD_DEPTH];
    logic [7:0]       n_pay [PAYLOAD_DEPTH];
    logic [2:0]       status;
    logic [8:0]       len_want;
    logic [7:0]       b;

    assign b = i_step.beat.rx_byte;

    // Byte update: the values a judgement at chunk end is made on.
    always_comb begin
        n_pos   = r_pos;
        n_first = r_first;
        n_type  = r_type;
        n_len   = r_len;
        n_prev  = r_prev;
        n_older = r_older;
        n_xor   = r_xor;
        for (int k = 0; k < PAYLOAD_DEPTH; k++) begin
            n_pay[k] = r_pay[k];
        end
        if (r_pos < POS_W'(MAX_CHUNK)) begin
            if (r_pos == '0) begin
                n_first = b;
            end else begin
                n_xor = r_xor ^ b;
            end
            if (r_pos == POS_W'(1)) n_type = b;
            if (r_pos == POS_W'(2)) n_len = b;
            for (int k = 0; k < PAYLOAD_DEPTH; k++) begin
                if (r_pos == POS_W'(k + PAYLOAD_FIRST)) n_pay[k] = b;
            end
            n_older = r_prev;
            n_prev  = b;
            n_pos   = r_pos + POS_W'(1);
        end
    end

    assign len_want = 9'(n_pos) - 9'd5;

    // Checks in priority order.
    always_comb begin
        if (n_pos < POS_W'(2) || n_first != HEADER_MARK || n_prev != TAIL_MARK) begin
            status = ST_FRAMING;
        end else if (n_type != TYPE_MARK) begin
            status = ST_TYPE;
        end else if (n_pos < POS_W'(5) || len_want != {1'b0, n_len}) begin
            status = ST_LENGTH;
        end else if (n_older != (n_xor ^ n_older ^ n_prev)) begin
            status = ST_CHECKSUM;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_result.status = status;
        if (status == ST_OK) begin
            o_result.humidity_raw    = {n_pay[0], n_pay[1]};
            o_result.temperature_raw = {n_pay[2], n_pay[3]};
            o_result.light_raw       = {n_pay[4], n_pay[5]};
            o_result.gas_raw         = {n_pay[6], n_pay[7]};
            o_result.soil_raw        = {n_pay[8], n_pay[9]};
        end else begin
            o_result.humidity_raw    = '0;
            o_result.temperature_raw = '0;
            o_result.light_raw       = '0;
            o_result.gas_raw         = '0;
            o_result.soil_raw        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.go && i_step.beat.chunk_end)) begin
            // clear at reset and after every chunk end
            r_pos   <= '0;
            r_first <= '0;
            r_type  <= '0;
            r_len   <= '0;
            r_prev  <= '0;
            r_older <= '0;
            r_xor   <= '0;
            for (int k = 0; k < PAYLOAD_DEPTH; k++) begin
                r_pay[k] <= '0;
            end
        end else if (i_step.go) begin
            r_pos   <= n_pos;
            r_first <= n_first;
            r_type  <= n_type;
            r_len   <= n_len;
            r_prev  <= n_prev;
            r_older <= n_older;
            r_xor   <= n_xor;
            for (int k = 0; k < PAYLOAD_DEPTH; k++) begin
                r_pay[k] <= n_pay[k];
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/sensor_frame_checker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sensor chunk checker. Takes one received byte per beat, a flag marking the
// last byte of a chunk, and one byte per clock cycle sustained while no last
// byte waits for the output. Each byte sits in an input register and then
// updates the chunk state; the last byte of a chunk produces one result beat
// (status plus five big-endian raw sensor words) in the output register once
// it leaves the input register, which it does not while an earlier result
// beat is still held by the receiver; the input stalls for as long as that
// last byte waits. The cycle is set by the single-pass state update and check
// logic between those two registers. Bytes beyond MAX_CHUNK in a chunk are
// dropped; a failed check reports its status with all sensor words zero.
`include "sensor_frame_checker_core_macros.svh"
module sensor_frame_checker_core
    import sfc_pkg::*;
#(
    parameter int MAX_CHUNK = 50
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_beat i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_beat     o_out_data
);

    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;
    logic      out_free;
    logic      proc_go;
    logic      in_take;
    t_step_req step;
    t_out_beat result;

    assign out_free   = !r_out_valid || !i_out_stall;
    // non-final bytes never need the output slot
    assign proc_go    = r_in_valid && (!r_in.chunk_end || out_free);
    assign o_in_stall = r_in_valid && !proc_go;
    assign in_take    = i_in_valid && !o_in_stall;

    assign step.go   = proc_go;
    assign step.beat = r_in;

    sfc_frame_state #(
        .MAX_CHUNK(MAX_CHUNK)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_in <= i_in_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && r_in.chunk_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && r_in.chunk_end) r_out <= result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SFC_ASSERT(a_result_from_chunk_end, $rose(r_out_valid) |-> $past(proc_go && r_in.chunk_end), "result beat without a processed chunk end")
    `SFC_ASSERT(a_failed_words_zero, (r_out_valid && r_out.status != ST_OK) |-> (r_out.humidity_raw == '0 && r_out.temperature_raw == '0 && r_out.light_raw == '0 && r_out.gas_raw == '0 && r_out.soil_raw == '0), "failed chunk carries sensor words")
    `SFC_ASSERT(a_held_byte_kept, (r_in_valid && !proc_go) |=> (r_in_valid && $stable(r_in)), "waiting byte lost or overwritten")
    `SFC_ASSERT(a_no_overrun, (r_out_valid && i_out_stall) |-> !(proc_go && r_in.chunk_end), "result overwrites a waiting result")

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import sfc_pkg::*;

    localparam int MAX_KEPT     = 50;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 850;

    typedef enum int {
        FLAW_NONE,
        FLAW_HEADER,
        FLAW_TYPE,
        FLAW_LENGTH,
        FLAW_CHECKSUM,
        FLAW_TAIL
    } frame_flaw_e;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      tx_valid = 1'b0;
    t_in_beat  tx_beat = '0;
    logic      rx_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_data;

    sensor_frame_checker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (tx_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (tx_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (rx_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Chunk state of the predictor
    int         kept_count;
    logic [7:0] head_byte;
    logic [7:0] kind_byte;
    logic [7:0] len_byte;
    logic [7:0] last_kept;
    logic [7:0] prev_kept;
    logic [7:0] frame_xor;
    logic [7:0] sensor_bytes [10];

    t_out_beat  chunk_verdicts [$];
    logic [7:0] chunk_bytes [$];

    int   mismatches = 0;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    int   burst_left = 0;
    bit   tx_gaps_on = 1'b0;
    int   rx_mode = 0;
    logic [31:0] stall_pattern = '0;
    logic [5:0]  stall_phase = '0;

    function automatic void clear_chunk_state();
        kept_count = 0;
        head_byte  = '0;
        kind_byte  = '0;
        len_byte   = '0;
        last_kept  = '0;
        prev_kept  = '0;
        frame_xor  = '0;
        foreach (sensor_bytes[k]) sensor_bytes[k] = '0;
    endfunction

    function automatic void track_rx_byte(input t_in_beat b);
        t_out_beat  v;
        logic [7:0] body_xor;
        if (kept_count < MAX_KEPT) begin
            if (kept_count == 0) head_byte = b.rx_byte;
            else frame_xor = frame_xor ^ b.rx_byte;
            if (kept_count == 1) kind_byte = b.rx_byte;
            if (kept_count == 2) len_byte = b.rx_byte;
            if (kept_count >= PAYLOAD_FIRST && kept_count < PAYLOAD_FIRST + PAYLOAD_DEPTH)
                sensor_bytes[kept_count - PAYLOAD_FIRST] = b.rx_byte;
            prev_kept = last_kept;
            last_kept = b.rx_byte;
            kept_count++;
        end
        if (b.chunk_end) begin
            // XOR over type .. last payload byte: strip checksum and tail back out
            body_xor = frame_xor ^ prev_kept ^ last_kept;
            v = '0;
            if (kept_count < 2 || head_byte != HEADER_MARK || last_kept != TAIL_MARK)
                v.status = ST_FRAMING;
            else if (kind_byte != TYPE_MARK)
                v.status = ST_TYPE;
            else if (kept_count < 5 || int'(len_byte) != kept_count - 5)
                v.status = ST_LENGTH;
            else if (prev_kept != body_xor)
                v.status = ST_CHECKSUM;
            else
                v.status = ST_OK;
            if (v.status == ST_OK) begin
                v.humidity_raw    = {sensor_bytes[0], sensor_bytes[1]};
                v.temperature_raw = {sensor_bytes[2], sensor_bytes[3]};
                v.light_raw       = {sensor_bytes[4], sensor_bytes[5]};
                v.gas_raw         = {sensor_bytes[6], sensor_bytes[7]};
                v.soil_raw        = {sensor_bytes[8], sensor_bytes[9]};
            end
            chunk_verdicts.push_back(v);
            clear_chunk_state();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("ERROR at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
        mismatches++;
    endtask

    initial clear_chunk_state();

    always @(posedge i_clk) begin : beat_monitor
        t_out_beat want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (tx_valid && !o_in_stall)
                track_rx_byte(tx_beat);
            if (o_out_valid && !rx_stall) begin
                if (chunk_verdicts.size() == 0) begin
                    report_mismatch("unexpected result beat, status", '0,
                                    16'(o_out_data.status));
                end else begin
                    want = chunk_verdicts.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", 16'(want.status), 16'(o_out_data.status));
                    if (o_out_data.humidity_raw !== want.humidity_raw)
                        report_mismatch("humidity_raw", want.humidity_raw,
                                        o_out_data.humidity_raw);
                    if (o_out_data.temperature_raw !== want.temperature_raw)
                        report_mismatch("temperature_raw", want.temperature_raw,
                                        o_out_data.temperature_raw);
                    if (o_out_data.light_raw !== want.light_raw)
                        report_mismatch("light_raw", want.light_raw, o_out_data.light_raw);
                    if (o_out_data.gas_raw !== want.gas_raw)
                        report_mismatch("gas_raw", want.gas_raw, o_out_data.gas_raw);
                    if (o_out_data.soil_raw !== want.soil_raw)
                        report_mismatch("soil_raw", want.soil_raw, o_out_data.soil_raw);
                end
            end
        end
    end

    // Receiver back-pressure: off, a rolling pattern reloaded each time the phase counter wraps, or heavy
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 6'd1;
        if (stall_phase == '0)
            stall_pattern <= $urandom;
        case (rx_mode)
            1: rx_stall <= stall_pattern[stall_phase[4:0]];
            2: rx_stall <= ($urandom_range(0, 3) != 0);
            default: rx_stall <= 1'b0;
        endcase
    end

    task automatic send_beat(input logic [7:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = tx_gaps_on ? $urandom_range(1, 5) : 0;
            burst_left = $urandom_range(1, 16);
            repeat (gap) begin
                @(negedge i_clk);
                tx_valid <= 1'b0;
                tx_beat  <= t_in_beat'($urandom);
            end
        end
        burst_left--;
        @(negedge i_clk);
        tx_valid <= 1'b1;
        tx_beat  <= '{rx_byte: value, chunk_end: last};
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task automatic send_chunk();
        foreach (chunk_bytes[k])
            send_beat(chunk_bytes[k], k == chunk_bytes.size() - 1);
    endtask

    // fill < 0 gives random payload bytes
    task automatic build_frame(input int pay_len, input frame_flaw_e flaw, input int fill);
        logic [7:0] check_byte;
        logic [7:0] item;
        chunk_bytes.delete();
        chunk_bytes.push_back(flaw == FLAW_HEADER ?
                              HEADER_MARK ^ 8'($urandom_range(1, 255)) : HEADER_MARK);
        chunk_bytes.push_back(flaw == FLAW_TYPE ? 8'($urandom_range(1, 255)) : TYPE_MARK);
        chunk_bytes.push_back(flaw == FLAW_LENGTH ?
                              8'(pay_len) ^ 8'($urandom_range(1, 255)) : 8'(pay_len));
        check_byte = chunk_bytes[1] ^ chunk_bytes[2];
        for (int k = 0; k < pay_len; k++) begin
            if (fill >= 0) item = 8'(fill);
            else begin
                case ($urandom_range(0, 5))
                    0: item = 8'h00;
                    1: item = 8'hff;
                    default: item = 8'($urandom);
                endcase
            end
            chunk_bytes.push_back(item);
            check_byte = check_byte ^ item;
        end
        chunk_bytes.push_back(flaw == FLAW_CHECKSUM ?
                              check_byte ^ 8'($urandom_range(1, 255)) : check_byte);
        chunk_bytes.push_back(flaw == FLAW_TAIL ?
                              TAIL_MARK ^ 8'($urandom_range(1, 255)) : TAIL_MARK);
    endtask

    task automatic test_short_chunks();
        chunk_bytes = '{HEADER_MARK};
        send_chunk();
        chunk_bytes = '{8'hff};
        send_chunk();
        chunk_bytes = '{HEADER_MARK, TAIL_MARK};
        send_chunk();
    endtask

    task automatic test_status_codes();
        // Minimal passing chunk: the humidity word picks up checksum and tail
        build_frame(0, FLAW_NONE, 0);
        send_chunk();
        build_frame(2, FLAW_NONE, 8'hff);
        send_chunk();
        build_frame(0, FLAW_TYPE, 0);
        send_chunk();
        build_frame(0, FLAW_LENGTH, 0);
        send_chunk();
        build_frame(0, FLAW_CHECKSUM, 0);
        send_chunk();
    endtask

    task automatic test_random_chunks();
        int start_count;
        int chunk_idx;
        int pick;
        int pay_len;
        start_count = bytes_sent;
        chunk_idx = 0;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            case ((chunk_idx / 12) % 4)
                0: begin tx_gaps_on = 1'b1; rx_mode = 1; end
                1: begin tx_gaps_on = 1'b0; rx_mode = 0; end
                2: begin tx_gaps_on = 1'b1; rx_mode = 0; end
                default: begin tx_gaps_on = 1'b0; rx_mode = 2; end
            endcase
            pick = $urandom_range(0, 99);
            pay_len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                                   : $urandom_range(13, MAX_KEPT - 5);
            if (chunk_idx % 16 == 15) begin
                // Fill the kept window exactly, then pad with bytes that must be dropped
                build_frame(MAX_KEPT - 5,
                            (pick < 70) ? FLAW_NONE : frame_flaw_e'($urandom_range(1, 5)), -1);
                repeat ($urandom_range(1, 8)) chunk_bytes.push_back(8'($urandom));
            end else if (pick < 60) begin
                build_frame(pay_len, FLAW_NONE, -1);
            end else if (pick < 80) begin
                build_frame(pay_len, frame_flaw_e'($urandom_range(1, 5)), -1);
            end else if (pick < 90) begin
                build_frame(pay_len, FLAW_NONE, -1);
                repeat ($urandom_range(1, chunk_bytes.size() - 1)) void'(chunk_bytes.pop_back());
            end else begin
                chunk_bytes.delete();
                repeat ($urandom_range(1, 20)) chunk_bytes.push_back(8'($urandom));
                if ($urandom_range(0, 1)) begin
                    chunk_bytes[0] = HEADER_MARK;
                    chunk_bytes[chunk_bytes.size() - 1] = TAIL_MARK;
                end
            end
            send_chunk();
            chunk_idx++;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_short_chunks();
        test_status_codes();
        test_random_chunks();
        @(negedge i_clk);
        tx_valid <= 1'b0;
        rx_mode = 1;
        while (chunk_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
